// ===== sv/a64dec_pkg.sv =====
// Package: shared types and encodings of the ARM64 subset instruction decoder.
`timescale 1ns / 1ps
`default_nettype none

package a64dec_pkg;

   // ALU operation codes
   localparam logic [3:0] ALU_NONE = 4'd0;
   localparam logic [3:0] ALU_AND  = 4'd1;
   localparam logic [3:0] ALU_OR   = 4'd2;
   localparam logic [3:0] ALU_ADD  = 4'd3;
   localparam logic [3:0] ALU_MUL  = 4'd4;
   localparam logic [3:0] ALU_XOR  = 4'd5;
   localparam logic [3:0] ALU_SUB  = 4'd6;
   localparam logic [3:0] ALU_TST0 = 4'd7;
   localparam logic [3:0] ALU_MOV  = 4'd8;
   localparam logic [3:0] ALU_SHL  = 4'd9;
   localparam logic [3:0] ALU_SHR  = 4'd10;

   // memory operation codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   // control flow kinds
   localparam logic [2:0] FLOW_NONE  = 3'd0;
   localparam logic [2:0] FLOW_BCOND = 3'd1;
   localparam logic [2:0] FLOW_CBZ   = 3'd2;
   localparam logic [2:0] FLOW_CBNZ  = 3'd3;
   localparam logic [2:0] FLOW_B     = 3'd4;
   localparam logic [2:0] FLOW_BR    = 3'd5;
   localparam logic [2:0] FLOW_HALT  = 3'd6;

   // bitfield imms value that marks the LSR alias
   localparam logic [5:0] IMMS_ALL_ONES = 6'h3f;

   typedef struct packed {
      logic [3:0]         alu_op;
      logic signed [27:0] immediate;
      logic [4:0]         src_a_reg;
      logic [4:0]         src_b_reg;
      logic [4:0]         dest_reg;
      logic [3:0]         branch_cond;
      logic               use_imm;
      logic               reg_write;
      logic               set_flags;
      logic [1:0]         mem_op;
      logic [1:0]         mem_size;
      logic [2:0]         flow_kind;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/a64dec_req_if.sv =====
// Interface: instruction request channel.
`timescale 1ns / 1ps
`default_nettype none

interface a64dec_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

`default_nettype wire

// ===== sv/a64dec_rsp_if.sv =====
// Interface: decoded control response channel.
`timescale 1ns / 1ps
`default_nettype none

interface a64dec_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         alu_op;
   logic signed [27:0] immediate;
   logic [4:0]         src_a_reg;
   logic [4:0]         src_b_reg;
   logic [4:0]         dest_reg;
   logic [3:0]         branch_cond;
   logic               use_imm;
   logic               reg_write;
   logic               set_flags;
   logic [1:0]         mem_op;
   logic [1:0]         mem_size;
   logic [2:0]         flow_kind;

   modport source (output valid, output alu_op, output immediate, output src_a_reg,
                   output src_b_reg, output dest_reg, output branch_cond,
                   output use_imm, output reg_write, output set_flags,
                   output mem_op, output mem_size, output flow_kind, input ready);
   modport sink   (input valid, input alu_op, input immediate, input src_a_reg,
                   input src_b_reg, input dest_reg, input branch_cond,
                   input use_imm, input reg_write, input set_flags,
                   input mem_op, input mem_size, input flow_kind, output ready);
endinterface

`default_nettype wire

// ===== sv/a64dec_decode.sv =====
// Combinational decode of one instruction word into its control fields.
`timescale 1ns / 1ps
`default_nettype none

module a64dec_decode
   import a64dec_pkg::*;
(
   input  wire logic [31:0] instruction,
   output rsp_type          ctrl
);

   logic [31:0] w;
   logic [2:0]  sub;
   logic [5:0]  imms;
   logic [5:0]  immr;
   logic [2:0]  top;
   logic [3:0]  op1;
   logic [3:0]  op2;
   logic [1:0]  opc;
   logic        rt_as_b;
   logic signed [27:0] off19;
   logic signed [27:0] off26;
   logic signed [27:0] off9;

   assign w     = instruction;
   assign sub   = w[25:23];
   assign imms  = w[15:10];
   assign immr  = w[21:16];
   assign top   = w[31:29];
   assign op1   = w[25:22];
   assign op2   = w[24:21];
   // branch and load/store offsets in bytes
   assign off19 = {{7{w[23]}}, w[23:5], 2'b00};
   assign off26 = {w[25:0], 2'b00};
   assign off9  = {{19{w[20]}}, w[20:12]};

   always_comb begin
      ctrl             = '0;
      rt_as_b          = 1'b0;
      opc              = w[23:22];
      ctrl.src_a_reg   = w[9:5];
      ctrl.dest_reg    = w[4:0];

      if (w[28:26] == 3'b100) begin
         // data processing, immediate
         ctrl.use_imm   = 1'b1;
         ctrl.reg_write = 1'b1;
         if (sub[2:1] == 2'b01) begin
            ctrl.alu_op    = w[30] ? ALU_SUB : ALU_ADD;
            ctrl.set_flags = w[29];
            ctrl.immediate = {16'd0, w[21:10]};
         end else if (sub == 3'd5) begin
            ctrl.alu_op    = ALU_MOV;
            ctrl.immediate = {12'd0, w[20:5]};
         end else if (sub == 3'd6) begin
            if (imms == IMMS_ALL_ONES) begin
               ctrl.alu_op    = ALU_SHR;
               ctrl.immediate = {22'd0, immr};
            end else if (({1'b0, imms} + 7'd1) == {1'b0, immr}) begin
               ctrl.alu_op    = ALU_SHL;
               ctrl.immediate = {22'd0, ~imms};
            end
         end
      end else if (w[28:26] == 3'b101) begin
         // branches and system
         if (top == 3'd6) begin
            if (op1 < 4'd4) begin
               ctrl.flow_kind = FLOW_HALT;
            end else if (op1 >= 4'd8) begin
               ctrl.flow_kind = FLOW_BR;
            end
         end else if (top == 3'd2 && op1 < 4'd8) begin
            ctrl.flow_kind   = FLOW_BCOND;
            ctrl.branch_cond = w[3:0];
            ctrl.immediate   = off19;
         end else if (top[1:0] == 2'd0) begin
            ctrl.flow_kind = FLOW_B;
            ctrl.immediate = off26;
         end else if (top[1:0] == 2'd1 && op1 < 4'd8) begin
            ctrl.flow_kind = w[24] ? FLOW_CBNZ : FLOW_CBZ;
            rt_as_b        = 1'b1;
            ctrl.alu_op    = ALU_TST0;
            ctrl.immediate = off19;
         end
      end else if (w[25] == 1'b0 && w[27] == 1'b1) begin
         // loads and stores
         ctrl.immediate = off9;
         ctrl.use_imm   = 1'b1;
         ctrl.alu_op    = ALU_ADD;
         if (w[29:28] == 2'b11 && !w[24] && !w[21] && w[11:10] == 2'b00) begin
            if (opc == 2'd0) begin
               ctrl.mem_op = MEM_STORE;
               rt_as_b     = 1'b1;
            end else if (opc == 2'd1) begin
               ctrl.mem_op    = MEM_LOAD;
               ctrl.reg_write = 1'b1;
            end
            ctrl.mem_size = w[31:30];
         end
      end else if (w[27:25] == 3'b101) begin
         // data processing, register
         ctrl.reg_write = 1'b1;
         if (!w[28]) begin
            if (op2 < 4'd8) begin
               case (w[30:29])
                  2'd1:    ctrl.alu_op = ALU_OR;
                  2'd2:    ctrl.alu_op = ALU_XOR;
                  default: ctrl.alu_op = ALU_AND;
               endcase
               ctrl.set_flags = (w[30:29] == 2'd3);
            end else begin
               ctrl.alu_op    = w[30] ? ALU_SUB : ALU_ADD;
               ctrl.set_flags = w[29];
               ctrl.immediate = {16'd0, w[21:10]};
            end
         end else if (op2 >= 4'd8) begin
            ctrl.alu_op = ALU_MUL;
         end
      end

      ctrl.src_b_reg = rt_as_b ? w[4:0] : w[20:16];
   end

endmodule

`default_nettype wire

// ===== sv/arm64_subset_instruction_decoder.sv =====
// Top level: registered decoder for a 64-bit ARM instruction subset.
`timescale 1ns / 1ps
`default_nettype none

// One 32-bit instruction word goes in on req_chan and one response with its
// decoded controls comes out on rsp_chan. The block is a two-register
// pipeline: the instruction register captures the word on a transfer, the
// decode logic works on it, and the response register holds the result
// until the sink takes it. A new instruction is taken every cycle while the
// response side keeps draining. Each word is decoded from the instruction
// register and its response becomes valid once it is in the response
// register. When the sink stalls, both registers fill and
// req_chan.ready drops; nothing is dropped or repeated. There is no
// configuration and no state beyond the pipeline registers. Controls that
// the decode does not assign come out as zero; the register number fields
// always carry the instruction bits.
module arm64_subset_instruction_decoder
   import a64dec_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   a64dec_req_if.sink    req_chan,
   a64dec_rsp_if.source  rsp_chan
);

   // instruction register
   logic        inst_valid_ff;
   logic        inst_valid_in;
   logic [31:0] inst_ff;
   // response register
   logic        out_valid_ff;
   logic        out_valid_in;
   rsp_type     out_ff;
   rsp_type     dec_ctrl;

   logic        inst_adv;   // decoded word moves into the response register
   logic        req_xfer;   // request transfer this cycle

   a64dec_decode u_decode (
      .instruction (inst_ff),
      .ctrl        (dec_ctrl)
   );

   // response register frees when empty or when the sink takes it
   assign inst_adv       = inst_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !inst_valid_ff || inst_adv;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      inst_valid_in = inst_valid_ff;
      if (req_xfer) begin
         inst_valid_in = 1'b1;
      end else if (inst_adv) begin
         inst_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (inst_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inst_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         inst_valid_ff <= inst_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         inst_ff <= req_chan.instruction;
      end
      if (inst_adv) begin
         out_ff <= dec_ctrl;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.alu_op      = out_ff.alu_op;
   assign rsp_chan.immediate   = out_ff.immediate;
   assign rsp_chan.src_a_reg   = out_ff.src_a_reg;
   assign rsp_chan.src_b_reg   = out_ff.src_b_reg;
   assign rsp_chan.dest_reg    = out_ff.dest_reg;
   assign rsp_chan.branch_cond = out_ff.branch_cond;
   assign rsp_chan.use_imm     = out_ff.use_imm;
   assign rsp_chan.reg_write   = out_ff.reg_write;
   assign rsp_chan.set_flags   = out_ff.set_flags;
   assign rsp_chan.mem_op      = out_ff.mem_op;
   assign rsp_chan.mem_size    = out_ff.mem_size;
   assign rsp_chan.flow_kind   = out_ff.flow_kind;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the ARM64 subset instruction decoder: directed and random decode checks.
`timescale 1ns / 1ps

module testbench;
   import a64dec_pkg::*;

   // Run-length knobs
   localparam int RANDOM_ITEMS   = 400;
   localparam int MAX_GAP        = 19;   // longest idle draw on either side
   localparam int WATCHDOG_LIMIT = 400;  // cycles without any transfer
   localparam int DRAIN_CYCLES   = 8;    // margin after the last response

   // Major opcode fields used to build directed encodings
   localparam logic [5:0]  ADDSUB_IMM_OP    = 6'b100010;  // bits 28:23
   localparam logic [5:0]  MOVE_WIDE_OP     = 6'b100101;  // bits 28:23
   localparam logic [5:0]  BITFIELD_OP      = 6'b100110;  // bits 28:23
   localparam logic [4:0]  LOGICAL_REG_OP   = 5'b01010;   // bits 28:24
   localparam logic [4:0]  ADDSUB_REG_OP    = 5'b01011;   // bits 28:24
   localparam logic [4:0]  DP3_OP           = 5'b11011;   // bits 28:24, multiply
   localparam logic [4:0]  DP_REG_OTHER_OP  = 5'b11010;   // bits 28:24, op2 below 8
   localparam logic [7:0]  BCOND_OP         = 8'b01010100;
   localparam logic [4:0]  B_OP             = 5'b00101;   // bits 30:26
   localparam logic [5:0]  CB_OP            = 6'b011010;  // bits 30:25
   localparam logic [6:0]  BR_OP            = 7'b1101011;
   localparam logic [10:0] HLT_OP           = 11'b11010100010;
   localparam logic [2:0]  LDST_UNSCALED_OP = 3'b111;     // bits 29:27

   localparam logic [1:0] LOGIC_AND  = 2'b00;
   localparam logic [1:0] LOGIC_ORR  = 2'b01;
   localparam logic [1:0] LOGIC_EOR  = 2'b10;
   localparam logic [1:0] LOGIC_ANDS = 2'b11;

   localparam logic [1:0] LDST_OPC_STORE  = 2'b00;
   localparam logic [1:0] LDST_OPC_LOAD   = 2'b01;
   localparam logic [1:0] LDST_OPC_SIGNED = 2'b10;

   localparam logic [1:0] SIZE_BYTE   = 2'b00;
   localparam logic [1:0] SIZE_HALF   = 2'b01;
   localparam logic [1:0] SIZE_DOUBLE = 2'b11;

   // Random instruction shapes: each pins the bits that select one decode path or class; SHAPE_ANY pins none
   typedef enum int {
      SHAPE_ANY,
      SHAPE_ADDSUB_IMM,
      SHAPE_MOVE_WIDE,
      SHAPE_BITFIELD,
      SHAPE_IMM_CLASS,
      SHAPE_BCOND,
      SHAPE_B,
      SHAPE_CB,
      SHAPE_BR_HLT,
      SHAPE_LDST_UNSCALED,
      SHAPE_LDST_CLASS,
      SHAPE_DP_REG,
      SHAPE_MUL,
      SHAPE_COUNT
   } encoding_shape_type;

   // One instruction in flight with the controls it must decode to
   typedef struct {
      logic [31:0] word;
      rsp_type     controls;
   } decode_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   a64dec_req_if req_chan ();
   a64dec_rsp_if rsp_chan ();

   arm64_subset_instruction_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   decode_record_type expected_controls[$];
   int             mismatch_count = 0;
   int             stalled_cycles = 0;
   int             sink_hold      = 0;
   bit             source_burst   = 1'b0;  // no gaps between request transfers
   bit             sink_burst     = 1'b0;  // no stalls on the response side

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Decode predictor. No state: every word maps to one set of controls.
   // ------------------------------------------------------------------
   function automatic rsp_type decode_instruction(input logic [31:0] w);
      rsp_type    d;
      logic [3:0] cls;
      logic [2:0] top;
      logic [3:0] op1;
      logic [5:0] imms;
      logic [5:0] immr;
      logic [1:0] opc;
      logic       rt_as_b;
      d         = '0;
      rt_as_b   = 1'b0;
      cls       = w[28:25];
      d.src_a_reg = w[9:5];
      d.dest_reg  = w[4:0];
      if (cls[3:1] == 3'b100) begin
         // data processing immediate: always writes, always uses imm
         d.use_imm   = 1'b1;
         d.reg_write = 1'b1;
         if (w[25:24] == 2'b01) begin
            // add/sub immediate; shift bit 22 ignored
            d.alu_op    = w[30] ? ALU_SUB : ALU_ADD;
            d.set_flags = w[29];
            d.immediate = {16'd0, w[21:10]};
         end else if (w[25:23] == 3'b101) begin
            // move wide; hw shift ignored
            d.alu_op    = ALU_MOV;
            d.immediate = {12'd0, w[20:5]};
         end else if (w[25:23] == 3'b110) begin
            imms = w[15:10];
            immr = w[21:16];
            if (imms == IMMS_ALL_ONES) begin
               d.alu_op    = ALU_SHR;
               d.immediate = {22'd0, immr};
            end else if ({1'b0, imms} + 7'd1 == {1'b0, immr}) begin
               d.alu_op    = ALU_SHL;
               d.immediate = {22'd0, ~imms};
            end
         end
      end else if (cls[3:1] == 3'b101) begin
         // branches, exception generation, system
         top = w[31:29];
         op1 = w[25:22];
         if (top == 3'b110) begin
            if (op1 < 4'd4)
               d.flow_kind = FLOW_HALT;
            else if (op1 >= 4'd8)
               d.flow_kind = FLOW_BR;
         end else if (top == 3'b010 && op1 < 4'd8) begin
            d.flow_kind   = FLOW_BCOND;
            d.branch_cond = w[3:0];
            d.immediate   = {{7{w[23]}}, w[23:5], 2'b00};
         end else if (top[1:0] == 2'b00) begin
            // link bit 31 is ignored: bl decodes as b
            d.flow_kind = FLOW_B;
            d.immediate = {w[25:0], 2'b00};
         end else if (top[1:0] == 2'b01 && op1 < 4'd8) begin
            d.flow_kind = w[24] ? FLOW_CBNZ : FLOW_CBZ;
            d.alu_op    = ALU_TST0;
            d.immediate = {{7{w[23]}}, w[23:5], 2'b00};
            rt_as_b     = 1'b1;
         end
      end else if (cls[2] && !cls[0]) begin
         // load/store class: offset and address add apply to every word
         d.immediate = {{19{w[20]}}, w[20:12]};
         d.use_imm   = 1'b1;
         d.alu_op    = ALU_ADD;
         if (w[29:28] == 2'b11 && !w[24] && !w[21] && w[11:10] == 2'b00) begin
            opc = w[23:22];
            if (opc == LDST_OPC_STORE) begin
               d.mem_op = MEM_STORE;
               rt_as_b  = 1'b1;
            end else if (opc == LDST_OPC_LOAD) begin
               d.mem_op    = MEM_LOAD;
               d.reg_write = 1'b1;
            end
            d.mem_size = w[31:30];
         end
      end else if (cls[2:0] == 3'b101) begin
         // data processing register
         d.reg_write = 1'b1;
         if (!w[28]) begin
            if (!w[24]) begin
               opc = w[30:29];
               d.alu_op    = (opc == LOGIC_ORR) ? ALU_OR :
                             (opc == LOGIC_EOR) ? ALU_XOR : ALU_AND;
               d.set_flags = (opc == LOGIC_ANDS);
            end else begin
               d.alu_op    = w[30] ? ALU_SUB : ALU_ADD;
               d.set_flags = w[29];
               d.immediate = {16'd0, w[21:10]};
            end
         end else if (w[24]) begin
            d.alu_op = ALU_MUL;
         end
      end
      d.src_b_reg = rt_as_b ? w[4:0] : w[20:16];
      return d;
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting: one line per mismatch
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input logic [31:0] word, input string field,
                                input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("instr %08h %s: got %0h, expected %0h",
                                   word, field, got, want));
   endtask

   // ------------------------------------------------------------------
   // Request side: one transfer per call, random gap in front of it.
   // Called at a rising edge, returns at the edge of the transfer with
   // valid still high so back-to-back items never toggle it in one step.
   // ------------------------------------------------------------------
   task automatic send_instruction(input logic [31:0] word);
      int unsigned gap;
      gap = source_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.instruction <= word;
      do @(posedge clock); while (!req_chan.ready);
      expected_controls.push_back('{word, decode_instruction(word)});
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall after each transfer, bursts without one
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready)
         sink_hold = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      else if (sink_hold > 0)
         sink_hold--;
      rsp_chan.ready <= (sink_hold == 0);
   end

   // Every response transfer is checked against the oldest pending decode
   always @(posedge clock) begin : response_check
      decode_record_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_controls.size() == 0) begin
            report_mismatch($sformatf("response transfer with nothing pending, alu_op %0h",
                                      rsp_chan.alu_op));
         end else begin
            want = expected_controls.pop_front();
            compare_field(want.word, "alu_op", 32'(rsp_chan.alu_op),
                          32'(want.controls.alu_op));
            compare_field(want.word, "immediate", 32'(rsp_chan.immediate),
                          32'(want.controls.immediate));
            compare_field(want.word, "src_a_reg", 32'(rsp_chan.src_a_reg),
                          32'(want.controls.src_a_reg));
            compare_field(want.word, "src_b_reg", 32'(rsp_chan.src_b_reg),
                          32'(want.controls.src_b_reg));
            compare_field(want.word, "dest_reg", 32'(rsp_chan.dest_reg),
                          32'(want.controls.dest_reg));
            compare_field(want.word, "branch_cond", 32'(rsp_chan.branch_cond),
                          32'(want.controls.branch_cond));
            compare_field(want.word, "use_imm", 32'(rsp_chan.use_imm),
                          32'(want.controls.use_imm));
            compare_field(want.word, "reg_write", 32'(rsp_chan.reg_write),
                          32'(want.controls.reg_write));
            compare_field(want.word, "set_flags", 32'(rsp_chan.set_flags),
                          32'(want.controls.set_flags));
            compare_field(want.word, "mem_op", 32'(rsp_chan.mem_op),
                          32'(want.controls.mem_op));
            compare_field(want.word, "mem_size", 32'(rsp_chan.mem_size),
                          32'(want.controls.mem_size));
            compare_field(want.word, "flow_kind", 32'(rsp_chan.flow_kind),
                          32'(want.controls.flow_kind));
         end
      end
   end

   // Watchdog: too long without a transfer on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // add/sub immediate, move wide, and the bitfield shift aliases
   task automatic test_immediate_forms();
      // add, largest imm12, shift bit set (ignored)
      send_instruction({1'b1, 1'b0, 1'b0, ADDSUB_IMM_OP, 1'b1, 12'hfff, 5'd0, 5'd31});
      // subs, zero imm, register 31 as the first source
      send_instruction({1'b1, 1'b1, 1'b1, ADDSUB_IMM_OP, 1'b0, 12'h000, 5'd31, 5'd0});
      // movz, all-ones imm16, hw field ignored
      send_instruction({1'b1, 2'b10, MOVE_WIDE_OP, 2'b11, 16'hffff, 5'd31});
      // lsr: imms all ones, shift in immr
      send_instruction({1'b1, 2'b10, BITFIELD_OP, 1'b1, 6'd63, IMMS_ALL_ONES, 5'd1, 5'd2});
      // lsl #1 and lsl #63: imms + 1 == immr
      send_instruction({1'b1, 2'b10, BITFIELD_OP, 1'b1, 6'd63, 6'd62, 5'd3, 5'd4});
      send_instruction({1'b1, 2'b10, BITFIELD_OP, 1'b1, 6'd1, 6'd0, 5'd5, 5'd6});
      // bitfield that is neither alias: only reg_write and use_imm
      send_instruction({1'b1, 2'b10, BITFIELD_OP, 1'b1, 6'd7, 6'd2, 5'd7, 5'd8});
   endtask

   // logical and add/sub shifted register, multiply, other register ops
   task automatic test_register_forms();
      send_instruction({1'b1, LOGIC_AND, LOGICAL_REG_OP, 2'b00, 1'b0, 5'd1, 6'd0, 5'd2, 5'd3});
      send_instruction({1'b0, LOGIC_ORR, LOGICAL_REG_OP, 2'b11, 1'b1, 5'd31, 6'h3f, 5'd31,
                        5'd31});
      send_instruction({1'b1, LOGIC_EOR, LOGICAL_REG_OP, 2'b01, 1'b0, 5'd10, 6'd5, 5'd11,
                        5'd12});
      send_instruction({1'b1, LOGIC_ANDS, LOGICAL_REG_OP, 2'b10, 1'b0, 5'd0, 6'd0, 5'd0,
                        5'd0});
      // adds register: imm carries bits 21:10
      send_instruction({1'b1, 1'b0, 1'b1, ADDSUB_REG_OP, 2'b00, 1'b0, 5'd31, 6'h3f, 5'd0,
                        5'd31});
      send_instruction({1'b1, 2'b00, DP3_OP, 3'b000, 5'd7, 1'b0, 5'd31, 5'd8, 5'd9});
      // bit 28 set, op2 below 8: register write only
      send_instruction({1'b1, 2'b00, DP_REG_OTHER_OP, 14'h0, 5'd5, 5'd6});
   endtask

   // conditional, unconditional, register, compare branches and halt
   task automatic test_branches();
      // b.cond, most negative offset
      send_instruction({BCOND_OP, 19'h40000, 1'b0, 4'hf});
      // b, most negative and most positive offset
      send_instruction({1'b0, B_OP, 26'h2000000});
      send_instruction({1'b0, B_OP, 26'h1ffffff});
      // bl decodes as plain b
      send_instruction({1'b1, B_OP, 26'h0000001});
      send_instruction({BR_OP, 4'b0000, 5'b11111, 6'd0, 5'd30, 5'd0});
      send_instruction({HLT_OP, 16'hffff, 5'd0});
      // cbz/cbnz: Rt goes out as the second source
      send_instruction({1'b1, CB_OP, 1'b0, 19'h7ffff, 5'd17});
      send_instruction({1'b0, CB_OP, 1'b1, 19'h3ffff, 5'd0});
   endtask

   // unscaled loads and stores, and load/store words outside that form
   task automatic test_memory();
      send_instruction({SIZE_BYTE, LDST_UNSCALED_OP, 3'b000, LDST_OPC_STORE, 1'b0, 9'h100,
                        2'b00, 5'd1, 5'd2});
      send_instruction({SIZE_HALF, LDST_UNSCALED_OP, 3'b000, LDST_OPC_LOAD, 1'b0, 9'h0ff,
                        2'b00, 5'd31, 5'd31});
      // opc 2: no memory op but size still decoded
      send_instruction({SIZE_DOUBLE, LDST_UNSCALED_OP, 3'b000, LDST_OPC_SIGNED, 1'b0, 9'h000,
                        2'b00, 5'd4, 5'd5});
      // bits 11:10 nonzero: offset only, no memory op
      send_instruction({SIZE_DOUBLE, LDST_UNSCALED_OP, 3'b000, LDST_OPC_LOAD, 1'b0, 9'h1ab,
                        2'b01, 5'd6, 5'd7});
   endtask

   // encodings outside the subset: only register fields survive
   task automatic test_unknown_encodings();
      send_instruction(32'h0000_0000);
      send_instruction(32'hffff_ffff);
   endtask

   // ------------------------------------------------------------------
   // Random stream
   // ------------------------------------------------------------------
   function automatic logic [31:0] random_instruction();
      encoding_shape_type shape;
      logic [31:0]        word;
      logic [31:0]        pin_mask;
      logic [31:0]        pin_bits;
      shape = encoding_shape_type'($urandom_range(0, SHAPE_COUNT - 1));
      word  = $urandom;
      case (shape)
         SHAPE_ADDSUB_IMM:    begin pin_mask = 32'h1f80_0000; pin_bits = 32'h1100_0000; end
         SHAPE_MOVE_WIDE:     begin pin_mask = 32'h1f80_0000; pin_bits = 32'h1280_0000; end
         SHAPE_BITFIELD:      begin pin_mask = 32'h1f80_0000; pin_bits = 32'h1300_0000; end
         SHAPE_IMM_CLASS:     begin pin_mask = 32'h1c00_0000; pin_bits = 32'h1000_0000; end
         SHAPE_BCOND:         begin pin_mask = 32'hff00_0000; pin_bits = 32'h5400_0000; end
         SHAPE_B:             begin pin_mask = 32'h7c00_0000; pin_bits = 32'h1400_0000; end
         SHAPE_CB:            begin pin_mask = 32'h7e00_0000; pin_bits = 32'h3400_0000; end
         SHAPE_BR_HLT:        begin pin_mask = 32'hfc00_0000; pin_bits = 32'hd400_0000; end
         SHAPE_LDST_UNSCALED: begin pin_mask = 32'h3b20_0c00; pin_bits = 32'h3800_0000; end
         SHAPE_LDST_CLASS:    begin pin_mask = 32'h0a00_0000; pin_bits = 32'h0800_0000; end
         SHAPE_DP_REG:        begin pin_mask = 32'h0e00_0000; pin_bits = 32'h0a00_0000; end
         SHAPE_MUL:           begin pin_mask = 32'h1f00_0000; pin_bits = 32'h1b00_0000; end
         default:             begin pin_mask = 32'h0;         pin_bits = 32'h0;         end
      endcase
      word = (word & ~pin_mask) | pin_bits;
      // steer bitfields toward the shift aliases most of the time
      if (shape == SHAPE_BITFIELD) begin
         case ($urandom_range(0, 2))
            0:       word[15:10] = IMMS_ALL_ONES;
            1:       word[21:16] = word[15:10] + 6'd1;
            default: ;
         endcase
      end
      return word;
   endfunction

   task automatic test_random_stream();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // new idle pattern every 40 items, sometimes a full-rate stretch
         if (n % 40 == 0) begin
            source_burst = ($urandom_range(0, 3) == 0);
            sink_burst   = ($urandom_range(0, 3) == 0);
         end
         send_instruction(random_instruction());
      end
      source_burst = 1'b0;
      sink_burst   = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.instruction <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_immediate_forms();
      test_register_forms();
      test_branches();
      test_memory();
      test_unknown_encodings();
      test_random_stream();

      // last transfer done; drain and give the pipeline time to misbehave
      req_chan.valid <= 1'b0;
      while (expected_controls.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/a64dec_pkg.sv
sv/a64dec_req_if.sv
sv/a64dec_rsp_if.sv
sv/a64dec_decode.sv
sv/arm64_subset_instruction_decoder.sv
test/testbench.sv
